// ----- rtl/core/rect_fill_clip_rotate_window_macros.svh -----
// assertion macros for the rectangle clip and rotate window block
// used by rect_fill_clip_rotate_window; no other dependencies
`ifndef RECT_FILL_CLIP_ROTATE_WINDOW_MACROS_SVH
`define RECT_FILL_CLIP_ROTATE_WINDOW_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define RFCRW_ASSERT_HOLDS(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RFCRW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define RFCRW_ASSERT_HOLDS(label, clk, rst_n, pre, post, msg)
`define RFCRW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- rtl/core/rfcrw_pkg.sv -----
// shared types and constants for the rectangle clip and rotate window block
// no dependencies; used by rfcrw_clip, rect_fill_clip_rotate_window and the testbench
`default_nettype none

package rfcrw_pkg;

  localparam int COORD_W     = 16;
  localparam int COLOR_W     = 18;
  localparam int WIN_W       = 9;
  localparam int HWIN_W      = 16;
  localparam int COUNT_W     = 17;
  localparam int EXT_W       = 18;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 112;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ROTATION   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PANEL_KIND = 1'd1;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef struct packed {
    rot_t rotation;
    logic panel_kind;
  } cfg_t;

  // one rectangle command
  typedef struct packed {
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic signed [COORD_W-1:0] rect_w;
    logic signed [COORD_W-1:0] rect_h;
    logic        [COLOR_W-1:0] pixel_color;
  } rect_t;

  // clipped and rotated window, before the pixel count
  typedef struct packed {
    logic               drawn;
    logic [WIN_W-1:0]   win_left;
    logic [WIN_W-1:0]   win_right;
    logic [WIN_W-1:0]   win_top;
    logic [WIN_W-1:0]   win_bottom;
    logic [WIN_W-1:0]   cursor_x;
    logic [WIN_W-1:0]   cursor_y;
    logic [WIN_W-1:0]   span_w;
    logic [WIN_W-1:0]   span_h;
    logic [COLOR_W-1:0] color;
  } geom_t;

endpackage

`default_nettype wire

// ----- rtl/core/rect_fill_clip_rotate_window.sv -----
// throughput: one rectangle per cycle unless out_tready stalls; four register stages
// (bounds, clip, rotate, pixel count multiply) each move on when the next one frees up
// reset: synchronous active-low rst_n clears all stage valids and sets
// rotation and panel kind to 0; the pipeline is empty after reset
`default_nettype none

`include "rect_fill_clip_rotate_window_macros.svh"

module rect_fill_clip_rotate_window #(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 320
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // configuration write port
  input  wire                                    cfg_wr_en,
  input  wire  [rfcrw_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [rfcrw_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
  // rectangle stream
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // rect_x, rect_y, rect_w, rect_h, pixel_color, zero pad
  input  wire  [rfcrw_pkg::IN_TDATA_W-1:0]       in_tdata,
  // window stream
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // win_left, win_right, win_top, win_bottom, hwin_packed, cursor_x,
  // cursor_y, pixel_count, fill_color, zero pad
  output logic [rfcrw_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // drawn
  output logic                                   out_tuser
);

  localparam int WW = rfcrw_pkg::WIN_W;
  localparam int CW = rfcrw_pkg::COUNT_W;
  localparam int PAD_W = rfcrw_pkg::OUT_TDATA_W - 4 * WW - rfcrw_pkg::HWIN_W
                         - 2 * WW - CW - rfcrw_pkg::COLOR_W;

  rfcrw_pkg::cfg_t  cfg_r;
  rfcrw_pkg::rect_t rect;
  rfcrw_pkg::geom_t geom;
  logic             geom_vld;
  logic             geom_rdy;

  // output stage registers
  logic                              out_vld_r;
  logic                              drawn_r;
  logic [WW-1:0]                     win_left_r, win_right_r, win_top_r, win_bottom_r;
  logic [rfcrw_pkg::HWIN_W-1:0]      hwin_r;
  logic [WW-1:0]                     cursor_x_r, cursor_y_r;
  logic [CW-1:0]                     count_r;
  logic [rfcrw_pkg::COLOR_W-1:0]     color_r;
  logic [2*WW-1:0]                   product;
  logic                              out_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation   <= rfcrw_pkg::ROT_0;
      cfg_r.panel_kind <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        rfcrw_pkg::REG_ROTATION:   cfg_r.rotation   <= rfcrw_pkg::rot_t'(cfg_wr_data[1:0]);
        rfcrw_pkg::REG_PANEL_KIND: cfg_r.panel_kind <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // unpack the input beat
  assign rect.rect_x      = in_tdata[15:0];
  assign rect.rect_y      = in_tdata[31:16];
  assign rect.rect_w      = in_tdata[47:32];
  assign rect.rect_h      = in_tdata[63:48];
  assign rect.pixel_color = in_tdata[81:64];

  rfcrw_clip #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .rect_i      (rect),
    .out_valid_o (geom_vld),
    .out_ready_i (geom_rdy),
    .geom_o      (geom)
  );

  // stage 4: pixel count and gating of a rejected rectangle
  assign out_en   = !out_vld_r || out_tready;
  assign geom_rdy = out_en;
  assign product  = (2*WW)'(geom.span_w) * (2*WW)'(geom.span_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= geom_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      drawn_r      <= geom.drawn;
      win_left_r   <= geom.drawn ? geom.win_left   : '0;
      win_right_r  <= geom.drawn ? geom.win_right  : '0;
      win_top_r    <= geom.drawn ? geom.win_top    : '0;
      win_bottom_r <= geom.drawn ? geom.win_bottom : '0;
      cursor_x_r   <= geom.drawn ? geom.cursor_x   : '0;
      cursor_y_r   <= geom.drawn ? geom.cursor_y   : '0;
      count_r      <= geom.drawn ? product[CW-1:0] : '0;
      hwin_r       <= (geom.drawn && cfg_r.panel_kind) ?
                      {geom.win_right[7:0], geom.win_left[7:0]} : '0;
      color_r      <= geom.color;
    end
  end

  // pack the output beat
  assign out_tvalid = out_vld_r;
  assign out_tuser  = drawn_r;
  assign out_tdata  = {{PAD_W{1'b0}}, color_r, count_r, cursor_y_r, cursor_x_r, hwin_r,
                       win_bottom_r, win_top_r, win_right_r, win_left_r};

  // checks
  `RFCRW_ASSERT_HOLDS(a_undrawn_zero, clk, rst_n, out_tvalid && !out_tuser,
    out_tdata[86:0] == 87'd0, "rejected rectangle carries window data")
  `RFCRW_ASSERT_HOLDS(a_drawn_count, clk, rst_n, out_tvalid && out_tuser,
    out_tdata[86:70] != 17'd0, "drawn rectangle has zero pixel count")
  `RFCRW_ASSERT_HOLDS(a_hwin_kind, clk, rst_n, out_tvalid && !cfg_r.panel_kind,
    out_tdata[51:36] == 16'd0, "packed window word set with separate registers")
  `RFCRW_ASSERT_HOLDS(a_stall_cause, clk, rst_n, !in_tready,
    out_tvalid && !out_tready, "input stalled without an output stall")

endmodule

`default_nettype wire

// ----- rtl/core/rfcrw_clip.sv -----
// three-stage bounds check, clip and rotation map for one rectangle per beat
// depends on rfcrw_pkg
`default_nettype none

module rfcrw_clip #(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 320
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire rfcrw_pkg::cfg_t  cfg_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire rfcrw_pkg::rect_t rect_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output rfcrw_pkg::geom_t    geom_o
);

  localparam int EW = rfcrw_pkg::EXT_W;
  localparam int WW = rfcrw_pkg::WIN_W;

  localparam logic signed [EW-1:0] PW_S  = EW'(PANEL_WIDTH);
  localparam logic signed [EW-1:0] PH_S  = EW'(PANEL_HEIGHT);
  localparam logic        [WW-1:0] PW_M1 = WW'(PANEL_WIDTH - 1);
  localparam logic        [WW-1:0] PH_M1 = WW'(PANEL_HEIGHT - 1);

  // stage valids and enables
  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic s1_en, s2_en, s3_en;

  // stage 1 registers: corners and early reject
  logic signed [EW-1:0]              s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;
  logic                              s1_bad_r;
  logic [rfcrw_pkg::COLOR_W-1:0]     s1_color_r;

  // stage 2 registers: clipped corners
  logic [WW-1:0]                     s2_x1_r, s2_y1_r, s2_x2_r, s2_y2_r;
  logic                              s2_drawn_r;
  logic [rfcrw_pkg::COLOR_W-1:0]     s2_color_r;

  // stage 3 register: native window
  rfcrw_pkg::geom_t                  s3_geom_r;

  logic signed [EW-1:0] scr_w, scr_h;
  logic        [WW-1:0] scr_w_m1, scr_h_m1;

  logic signed [EW-1:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic                 bad_nxt;
  logic [WW-1:0]        cx1_nxt, cy1_nxt, cx2_nxt, cy2_nxt;
  logic                 drawn_nxt;
  rfcrw_pkg::geom_t     geom_nxt;

  // enable chain fills bubbles while the far end is stalled
  assign s3_en      = !s3_vld_r || out_ready_i;
  assign s2_en      = !s2_vld_r || s3_en;
  assign s1_en      = !s1_vld_r || s2_en;
  assign in_ready_o = s1_en;

  // logical screen size for the current rotation
  assign scr_w    = cfg_i.rotation[0] ? PH_S : PW_S;
  assign scr_h    = cfg_i.rotation[0] ? PW_S : PH_S;
  assign scr_w_m1 = cfg_i.rotation[0] ? PH_M1 : PW_M1;
  assign scr_h_m1 = cfg_i.rotation[0] ? PW_M1 : PH_M1;

  // stage 1: far corners and reject of empty or right/below rectangles
  always_comb begin
    x1_nxt  = EW'(rect_i.rect_x);
    y1_nxt  = EW'(rect_i.rect_y);
    x2_nxt  = x1_nxt + EW'(rect_i.rect_w) - EW'(1);
    y2_nxt  = y1_nxt + EW'(rect_i.rect_h) - EW'(1);
    bad_nxt = (rect_i.rect_w <= 0) || (rect_i.rect_h <= 0) ||
              (x1_nxt >= scr_w) || (y1_nxt >= scr_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_x1_r    <= x1_nxt;
      s1_y1_r    <= y1_nxt;
      s1_x2_r    <= x2_nxt;
      s1_y2_r    <= y2_nxt;
      s1_bad_r   <= bad_nxt;
      s1_color_r <= rect_i.pixel_color;
    end
  end

  // stage 2: left/above reject and clip to the screen
  always_comb begin
    drawn_nxt = !s1_bad_r && !s1_x2_r[EW-1] && !s1_y2_r[EW-1];
    cx1_nxt   = s1_x1_r[EW-1] ? '0 : s1_x1_r[WW-1:0];
    cy1_nxt   = s1_y1_r[EW-1] ? '0 : s1_y1_r[WW-1:0];
    cx2_nxt   = (s1_x2_r >= scr_w) ? scr_w_m1 : s1_x2_r[WW-1:0];
    cy2_nxt   = (s1_y2_r >= scr_h) ? scr_h_m1 : s1_y2_r[WW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_x1_r    <= cx1_nxt;
      s2_y1_r    <= cy1_nxt;
      s2_x2_r    <= cx2_nxt;
      s2_y2_r    <= cy2_nxt;
      s2_drawn_r <= drawn_nxt;
      s2_color_r <= s1_color_r;
    end
  end

  // stage 3: map clipped corners to native panel coordinates
  always_comb begin
    geom_nxt        = '0;
    geom_nxt.drawn  = s2_drawn_r;
    geom_nxt.color  = s2_color_r;
    geom_nxt.span_w = s2_x2_r - s2_x1_r + WW'(1);
    geom_nxt.span_h = s2_y2_r - s2_y1_r + WW'(1);
    unique case (cfg_i.rotation)
      rfcrw_pkg::ROT_0: begin
        geom_nxt.win_left   = s2_x1_r;
        geom_nxt.win_right  = s2_x2_r;
        geom_nxt.win_top    = s2_y1_r;
        geom_nxt.win_bottom = s2_y2_r;
        geom_nxt.cursor_x   = s2_x1_r;
        geom_nxt.cursor_y   = s2_y1_r;
      end
      rfcrw_pkg::ROT_90: begin
        geom_nxt.win_left   = PW_M1 - s2_y2_r;
        geom_nxt.win_right  = PW_M1 - s2_y1_r;
        geom_nxt.win_top    = s2_x1_r;
        geom_nxt.win_bottom = s2_x2_r;
        geom_nxt.cursor_x   = PW_M1 - s2_y1_r;
        geom_nxt.cursor_y   = s2_x1_r;
      end
      rfcrw_pkg::ROT_180: begin
        geom_nxt.win_left   = PW_M1 - s2_x2_r;
        geom_nxt.win_right  = PW_M1 - s2_x1_r;
        geom_nxt.win_top    = PH_M1 - s2_y2_r;
        geom_nxt.win_bottom = PH_M1 - s2_y1_r;
        geom_nxt.cursor_x   = PW_M1 - s2_x1_r;
        geom_nxt.cursor_y   = PH_M1 - s2_y1_r;
      end
      rfcrw_pkg::ROT_270: begin
        geom_nxt.win_left   = s2_y1_r;
        geom_nxt.win_right  = s2_y2_r;
        geom_nxt.win_top    = PH_M1 - s2_x2_r;
        geom_nxt.win_bottom = PH_M1 - s2_x1_r;
        geom_nxt.cursor_x   = s2_y1_r;
        geom_nxt.cursor_y   = PH_M1 - s2_x1_r;
      end
      default: begin
        geom_nxt.win_left   = s2_x1_r;
        geom_nxt.win_right  = s2_x2_r;
        geom_nxt.win_top    = s2_y1_r;
        geom_nxt.win_bottom = s2_y2_r;
        geom_nxt.cursor_x   = s2_x1_r;
        geom_nxt.cursor_y   = s2_y1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_geom_r <= geom_nxt;
    end
  end

  assign out_valid_o = s3_vld_r;
  assign geom_o      = s3_geom_r;

endmodule

`default_nettype wire

// ----- test/tb_rect_fill_clip_rotate_window.sv -----
// testbench for rect_fill_clip_rotate_window: directed and random rectangles, checked
// against a typed-in or in-bench predicted clipped, rotated window for each beat
// depends on rfcrw_pkg and the rect_fill_clip_rotate_window rtl
`default_nettype none

module tb_rect_fill_clip_rotate_window;

  localparam int PANEL_W     = 240;
  localparam int PANEL_H     = 320;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_RECTS = 153;

  // expected window, one per rectangle
  typedef struct packed {
    bit         drawn;
    bit [8:0]   left;
    bit [8:0]   right;
    bit [8:0]   top;
    bit [8:0]   bottom;
    bit [15:0]  hwin;
    bit [8:0]   cur_x;
    bit [8:0]   cur_y;
    bit [16:0]  pix_count;
    bit [17:0]  color;
  } window_t;

  // one row of the directed table
  typedef struct packed {
    rfcrw_pkg::rot_t  rot;
    bit               kind;
    bit               typed;
    rfcrw_pkg::rect_t rect;
    window_t          want;
  } case_t;

  localparam window_t NO_WINDOW = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [rfcrw_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [rfcrw_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [rfcrw_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [rfcrw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;

  rect_fill_clip_rotate_window #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // local copy of the configuration
  rfcrw_pkg::rot_t mode_rot = rfcrw_pkg::ROT_0;
  bit      mode_kind = 1'b0;

  window_t window_q[$];
  case_t   plan [0:23];
  int      rects_sent = 0;
  int      windows_checked = 0;
  int      windows_drawn = 0;
  int      failures = 0;
  int      cycle_count = 0;
  int      hold_ask = 0;
  int      hold_done = 0;
  int      ready_gap = 0;
  bit      calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // clip to the logical screen, then map the corners to native panel space
  function automatic window_t predict_window(rfcrw_pkg::rect_t r);
    int x1, y1, x2, y2, sw, sh, l, rt, t, b, cx, cy, n;
    window_t w;
    x1 = r.rect_x;
    y1 = r.rect_y;
    w = '0;
    w.color = r.pixel_color;
    sw = mode_rot[0] ? PANEL_H : PANEL_W;
    sh = mode_rot[0] ? PANEL_W : PANEL_H;
    if (r.rect_w <= 0 || r.rect_h <= 0 || x1 >= sw || y1 >= sh) return w;
    x2 = x1 + int'(r.rect_w) - 1;
    y2 = y1 + int'(r.rect_h) - 1;
    if (x2 < 0 || y2 < 0) return w;
    if (x1 < 0) x1 = 0;
    if (y1 < 0) y1 = 0;
    if (x2 >= sw) x2 = sw - 1;
    if (y2 >= sh) y2 = sh - 1;
    case (mode_rot)
      rfcrw_pkg::ROT_0: begin
        l = x1; rt = x2; t = y1; b = y2; cx = l; cy = t;
      end
      rfcrw_pkg::ROT_90: begin
        l = PANEL_W - 1 - y2; rt = PANEL_W - 1 - y1; t = x1; b = x2; cx = rt; cy = t;
      end
      rfcrw_pkg::ROT_180: begin
        l = PANEL_W - 1 - x2; rt = PANEL_W - 1 - x1;
        t = PANEL_H - 1 - y2; b = PANEL_H - 1 - y1;
        cx = rt; cy = b;
      end
      default: begin
        l = y1; rt = y2; t = PANEL_H - 1 - x2; b = PANEL_H - 1 - x1; cx = l; cy = b;
      end
    endcase
    n = (x2 - x1 + 1) * (y2 - y1 + 1);
    w.drawn = 1'b1;
    w.left = l[8:0];
    w.right = rt[8:0];
    w.top = t[8:0];
    w.bottom = b[8:0];
    w.hwin = mode_kind ? {rt[7:0], l[7:0]} : 16'd0;
    w.cur_x = cx[8:0];
    w.cur_y = cy[8:0];
    w.pix_count = n[16:0];
    return w;
  endfunction

  function automatic window_t mk_window(bit d, int l, int rt, int t, int b, int hw,
                                        int cx, int cy, int n, int c);
    window_t w;
    w.drawn = d;
    w.left = l[8:0];
    w.right = rt[8:0];
    w.top = t[8:0];
    w.bottom = b[8:0];
    w.hwin = hw[15:0];
    w.cur_x = cx[8:0];
    w.cur_y = cy[8:0];
    w.pix_count = n[16:0];
    w.color = c[17:0];
    return w;
  endfunction

  function automatic case_t row(rfcrw_pkg::rot_t rot, bit kind, int x, int y, int w,
                                int h, int c, bit typed, window_t want);
    case_t k;
    k.rot = rot;
    k.kind = kind;
    k.typed = typed;
    k.rect.rect_x = x[15:0];
    k.rect.rect_y = y[15:0];
    k.rect.rect_w = w[15:0];
    k.rect.rect_h = h[15:0];
    k.rect.pixel_color = c[17:0];
    k.want = want;
    return k;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly rectangles near the screen, some tiny, some huge, some raw noise
  function automatic rfcrw_pkg::rect_t random_rect();
    int x, y, w, h, c, sw, sh, pick;
    rfcrw_pkg::rect_t r;
    sw = mode_rot[0] ? PANEL_H : PANEL_W;
    sh = mode_rot[0] ? PANEL_W : PANEL_H;
    pick = $urandom_range(0, 9);
    c = $urandom_range(0, 'h3FFFF);
    if (pick < 6) begin
      x = rand_between(-40, sw + 20);
      y = rand_between(-40, sh + 20);
      w = rand_between(-3, sw + 40);
      h = rand_between(-3, sh + 40);
    end else if (pick < 8) begin
      x = rand_between(0, sw - 1);
      y = rand_between(0, sh - 1);
      w = rand_between(1, 8);
      h = rand_between(1, 8);
    end else if (pick == 8) begin
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end else begin
      x = rand_between(-32768, sw);
      y = rand_between(-32768, sh);
      w = rand_between(1, 32767);
      h = rand_between(1, 32767);
    end
    r.rect_x = x[15:0];
    r.rect_y = y[15:0];
    r.rect_w = w[15:0];
    r.rect_h = h[15:0];
    r.pixel_color = c[17:0];
    return r;
  endfunction

  // offer one rectangle, with an occasional gap first; returns on the accepting edge
  task automatic put_rect(rfcrw_pkg::rect_t r, bit typed, window_t want);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, r.pixel_color, r.rect_h, r.rect_w, r.rect_y, r.rect_x};
    do @(posedge clk); while (!in_tready);
    window_q.push_back(typed ? want : predict_window(r));
    rects_sent++;
  endtask

  // stop sending and let every pending window drain out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(rfcrw_pkg::rot_t rot, bit kind);
    cfg_wr_en <= 1'b1;
    cfg_addr <= rfcrw_pkg::REG_ROTATION;
    cfg_wr_data <= rot;
    @(posedge clk);
    cfg_addr <= rfcrw_pkg::REG_PANEL_KIND;
    cfg_wr_data <= {1'b0, kind};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_rot = rot;
    mode_kind = kind;
  endtask

  task automatic show_window(string tag, window_t w);
    $display("  %s: drawn=%0d win=%0d..%0d x %0d..%0d hwin=%h cur=(%0d,%0d) n=%0d color=%h",
             tag, w.drawn, w.left, w.right, w.top, w.bottom, w.hwin, w.cur_x, w.cur_y,
             w.pix_count, w.color);
  endtask

  // result receiver: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_ask != hold_done) begin
      hold_done <= hold_ask;
      out_tready <= 1'b0;
      ready_gap <= LONG_HOLD;
    end else if (ready_gap > 1) begin
      ready_gap <= ready_gap - 1;
    end else if (ready_gap == 1) begin
      ready_gap <= 0;
      out_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      ready_gap <= $urandom_range(1, 13);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each output beat with the oldest expected window
  always @(posedge clk) begin
    window_t got;
    window_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.drawn = out_tuser;
      got.left = out_tdata[8:0];
      got.right = out_tdata[17:9];
      got.top = out_tdata[26:18];
      got.bottom = out_tdata[35:27];
      got.hwin = out_tdata[51:36];
      got.cur_x = out_tdata[60:52];
      got.cur_y = out_tdata[69:61];
      got.pix_count = out_tdata[86:70];
      got.color = out_tdata[104:87];
      if (window_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("window beat with nothing pending");
          show_window("actual", got);
        end
      end else begin
        want = window_q.pop_front();
        if (got != want) begin
          failures++;
          if (failures <= 10) begin
            $display("window %0d differs (rotation %0d, kind %0d)", windows_checked,
                     mode_rot, mode_kind);
            show_window("expected", want);
            show_window("actual", got);
          end
        end
      end
      windows_checked++;
      if (got.drawn) windows_drawn++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d windows pending", window_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rfcrw_pkg::rot_t rot;
    bit   kind;

    // directed table: reset mode first, where results can be typed in
    plan[0]  = row(rfcrw_pkg::ROT_0, 0, 0, 0, 240, 320, 'h3FFFF, 1,
                   mk_window(1, 0, 239, 0, 319, 0, 0, 0, 76800, 'h3FFFF));
    plan[1]  = row(rfcrw_pkg::ROT_0, 0, 0, 0, 0, 5, 'h15555, 1,
                   mk_window(0, 0, 0, 0, 0, 0, 0, 0, 0, 'h15555));
    plan[2]  = row(rfcrw_pkg::ROT_0, 0, 3, 4, 5, -32768, 'h2AAAA, 1,
                   mk_window(0, 0, 0, 0, 0, 0, 0, 0, 0, 'h2AAAA));
    plan[3]  = row(rfcrw_pkg::ROT_0, 0, 240, 0, 10, 10, 0, 1, NO_WINDOW);
    plan[4]  = row(rfcrw_pkg::ROT_0, 0, 0, 320, 10, 10, 'h3FFFF, 1,
                   mk_window(0, 0, 0, 0, 0, 0, 0, 0, 0, 'h3FFFF));
    plan[5]  = row(rfcrw_pkg::ROT_0, 0, -32768, -32768, 32767, 32767, 0, 1, NO_WINDOW);
    plan[6]  = row(rfcrw_pkg::ROT_0, 0, -100, -100, 32767, 32767, 'h12345, 1,
                   mk_window(1, 0, 239, 0, 319, 0, 0, 0, 76800, 'h12345));
    plan[7]  = row(rfcrw_pkg::ROT_0, 0, 32767, 32767, 32767, 32767, 'h3FFFF, 1,
                   mk_window(0, 0, 0, 0, 0, 0, 0, 0, 0, 'h3FFFF));
    plan[8]  = row(rfcrw_pkg::ROT_0, 0, 239, 319, 1, 1, 'h00001, 1,
                   mk_window(1, 239, 239, 319, 319, 0, 239, 319, 1, 'h00001));
    plan[9]  = row(rfcrw_pkg::ROT_0, 0, -1, -1, 2, 2, 'h20000, 1,
                   mk_window(1, 0, 0, 0, 0, 0, 0, 0, 1, 'h20000));
    // remaining rotations and the packed window word go through the predictor
    plan[10] = row(rfcrw_pkg::ROT_0, 1, 200, 300, 100, 100, 'h0F0F0, 0, NO_WINDOW);
    plan[11] = row(rfcrw_pkg::ROT_90, 0, 0, 0, 320, 240, 'h3FFFF, 0, NO_WINDOW);
    plan[12] = row(rfcrw_pkg::ROT_90, 0, 10, 20, 30, 40, 'h01234, 0, NO_WINDOW);
    plan[13] = row(rfcrw_pkg::ROT_90, 0, 319, 239, 1, 1, 'h3C3C3, 0, NO_WINDOW);
    plan[14] = row(rfcrw_pkg::ROT_90, 0, 300, 240, 5, 5, 'h00FFF, 0, NO_WINDOW);
    plan[15] = row(rfcrw_pkg::ROT_90, 1, 0, 0, 1, 1, 'h3F000, 0, NO_WINDOW);
    plan[16] = row(rfcrw_pkg::ROT_180, 1, 0, 0, 240, 320, 'h2AAAA, 0, NO_WINDOW);
    plan[17] = row(rfcrw_pkg::ROT_180, 1, 5, 7, 100, 50, 'h15555, 0, NO_WINDOW);
    plan[18] = row(rfcrw_pkg::ROT_180, 1, -5, -5, 32767, 32767, 'h00000, 0, NO_WINDOW);
    plan[19] = row(rfcrw_pkg::ROT_270, 1, 0, 0, 320, 240, 'h3FFFF, 0, NO_WINDOW);
    plan[20] = row(rfcrw_pkg::ROT_270, 1, 12, 34, 56, 78, 'h0ABCD, 0, NO_WINDOW);
    plan[21] = row(rfcrw_pkg::ROT_270, 1, 319, 0, 5, 5, 'h30303, 0, NO_WINDOW);
    plan[22] = row(rfcrw_pkg::ROT_270, 0, 0, 0, -1, -1, 'h11111, 0, NO_WINDOW);
    plan[23] = row(rfcrw_pkg::ROT_270, 0, -32768, 0, 32767, 10, 'h22222, 0, NO_WINDOW);

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    for (int i = 0; i < 24; i++) begin
      if (i == 0 || plan[i].rot != mode_rot || plan[i].kind != mode_kind) begin
        wait_idle();
        set_mode(plan[i].rot, plan[i].kind);
      end
      put_rect(plan[i].rect, plan[i].typed, plan[i].want);
    end

    // random phases: every rotation with both panel kinds, then random modes
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p < 8) begin
        rot = rfcrw_pkg::rot_t'(p % 4);
        kind = (p >= 4);
      end else begin
        rot = rfcrw_pkg::rot_t'($urandom_range(0, 3));
        kind = 1'($urandom_range(0, 1));
      end
      set_mode(rot, kind);
      if (p == PHASES - 1) calm <= 1'b1;
      for (int k = 0; k < PHASE_RECTS; k++) begin
        // long output hold while the sender keeps offering
        if (p == 2 && k == 40) hold_ask <= hold_ask + 1;
        // sender pause until the pipeline is empty
        if (p == 5 && k == 70) wait_idle();
        put_rect(random_rect(), 1'b0, NO_WINDOW);
      end
    end

    wait_idle();
    $display("%0d rectangles sent, %0d windows checked (%0d drawn)", rects_sent,
             windows_checked, windows_drawn);
    $display("covered all four rotations, both panel kinds, empty, clipped and huge rects");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rfcrw_pkg.sv
rtl/core/rfcrw_clip.sv
rtl/core/rect_fill_clip_rotate_window.sv
test/tb_rect_fill_clip_rotate_window.sv
